@@ rtl/core/jap_pkg.sv @@
// Shared constants, codes and types of the joint angle path interpolator.
package jap_pkg;

  // Field and register widths
  localparam int JOINT_W    = 2;
  localparam int ANGLE_W    = 24;
  localparam int INDEX_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int MASK_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  // Block limits
  localparam int JOINTS      = 4;
  localparam int MAX_SAMPLES = 64;

  // Internal widths
  localparam int ALU_W  = 27;
  localparam int ACC_W  = 26;
  localparam int DIV_W  = 6;
  localparam int REM2_W = 7;
  localparam int CNT_W  = 5;
  localparam int QUO_W  = 24;

  // Angle constants, Q.16
  localparam int PI_Q     = 205887;
  localparam int TWO_PI_Q = 411775;
  localparam int ANG_MIN  = -8388608;
  localparam int ANG_MAX  = 8388607;

  // Wrap reduction: lift by 2^LIFT_SHIFT turns, then reduce in RED_STEPS binary steps
  localparam int LIFT_SHIFT = 5;
  localparam int RED_STEPS  = 5;
  localparam int DIV_STEPS  = QUO_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC_MASK = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 4'd1;

  // Shared arithmetic unit operations
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_CSUB,
    ALU_CADD
  } alu_op_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WOFS,
    ST_WLIFT,
    ST_WRED,
    ST_WEND,
    ST_DIFF,
    ST_FOLD,
    ST_MAG,
    ST_DIV,
    ST_SQ,
    ST_SQ1,
    ST_EMIT
  } seq_state_t;

  // Stepper control
  typedef struct packed {
    logic load;
    logic advance;
  } step_ctl_t;

  // Stepper start values
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] sq;
    logic signed [ACC_W-1:0] sq1;
    logic [REM2_W-1:0]       rem;
    logic [REM2_W-1:0]       rem_step;
    logic [REM2_W-1:0]       two_d;
    logic                    periodic;
  } step_init_t;

endpackage

@@ rtl/core/jap_in_if.sv @@
// Input channel: one joint's start and goal angle.
interface jap_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [jap_pkg::JOINT_W-1:0]          joint_index;
  logic signed [jap_pkg::ANGLE_W-1:0]   start_angle;
  logic signed [jap_pkg::ANGLE_W-1:0]   goal_angle;

  modport source (output valid, output joint_index, output start_angle, output goal_angle,
                  input ready);
  modport sink (input valid, input joint_index, input start_angle, input goal_angle,
                output ready);
endinterface

@@ rtl/core/jap_out_if.sv @@
// Result channel: one interpolated path sample.
interface jap_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [jap_pkg::JOINT_W-1:0]          joint_tag;
  logic [jap_pkg::INDEX_W-1:0]          sample_index;
  logic signed [jap_pkg::ANGLE_W-1:0]   path_angle;
  logic                                 last_sample;

  modport source (output valid, output joint_tag, output sample_index, output path_angle,
                  output last_sample, input ready);
  modport sink (input valid, input joint_tag, input sample_index, input path_angle,
                input last_sample, output ready);
endinterface

@@ rtl/core/jap_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface jap_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [jap_pkg::CFG_IDX_W-1:0]       index;
  logic [jap_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/jap_alu.sv @@
// Shared add, subtract and conditional add/subtract unit of the sequencer.
module jap_alu (
  input  jap_pkg::alu_op_t                  op,
  input  logic signed [jap_pkg::ALU_W-1:0]  a,
  input  logic signed [jap_pkg::ALU_W-1:0]  b,
  output logic signed [jap_pkg::ALU_W-1:0]  y,
  output logic                              neg
);

  logic signed [jap_pkg::ALU_W-1:0] sum;
  logic signed [jap_pkg::ALU_W-1:0] dif;

  assign sum = a + b;
  assign dif = a - b;

  // Select result; conditional forms keep a when the condition fails
  always_comb begin
    unique case (op)
      jap_pkg::ALU_ADD: begin
        y   = sum;
        neg = sum[jap_pkg::ALU_W-1];
      end
      jap_pkg::ALU_SUB: begin
        y   = dif;
        neg = dif[jap_pkg::ALU_W-1];
      end
      jap_pkg::ALU_CSUB: begin
        neg = dif[jap_pkg::ALU_W-1];
        y   = neg ? a : dif;
      end
      jap_pkg::ALU_CADD: begin
        neg = a[jap_pkg::ALU_W-1];
        y   = neg ? sum : a;
      end
      default: begin
        y   = sum;
        neg = sum[jap_pkg::ALU_W-1];
      end
    endcase
  end

endmodule

@@ rtl/core/jap_step.sv @@
// Sample stepper: accumulates the rounded quotient step and wraps or saturates each sample.
module jap_step (
  input  logic                                clk,
  input  jap_pkg::step_ctl_t                  ctl,
  input  jap_pkg::step_init_t                 init,
  output logic signed [jap_pkg::ANGLE_W-1:0]  angle
);

  localparam int AW = jap_pkg::ACC_W;
  localparam int RW = jap_pkg::REM2_W;

  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] sq_r;
  logic signed [AW-1:0] sq1_r;
  logic [RW-1:0]        rem_r;
  logic [RW-1:0]        rem_step_r;
  logic [RW-1:0]        two_d_r;
  logic                 periodic_r;

  logic [RW:0]          rem_sum;
  logic [RW:0]          rem_red;
  logic                 carry;
  logic [RW-1:0]        rem_nxt;
  logic signed [AW-1:0] acc_nxt;
  logic signed [AW-1:0] sel;

  // Remainder of the rounded quotient: one carry into the step when it reaches 2d
  assign rem_sum = {1'b0, rem_r} + {1'b0, rem_step_r};
  assign rem_red = rem_sum - {1'b0, two_d_r};
  assign carry   = (rem_sum >= {1'b0, two_d_r});
  assign rem_nxt = carry ? rem_red[RW-1:0] : rem_sum[RW-1:0];
  assign acc_nxt = carry ? (acc_r + sq1_r) : (acc_r + sq_r);

  // Load start values or advance one sample
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r      <= init.acc;
      sq_r       <= init.sq;
      sq1_r      <= init.sq1;
      rem_r      <= init.rem;
      rem_step_r <= init.rem_step;
      two_d_r    <= init.two_d;
      periodic_r <= init.periodic;
    end else if (ctl.advance) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Wrap a periodic sample by one turn, saturate others to the field range
  always_comb begin
    if (periodic_r) begin
      priority if (acc_r < -jap_pkg::PI_Q) begin
        sel = acc_r + AW'(jap_pkg::TWO_PI_Q);
      end else if (acc_r >= (jap_pkg::TWO_PI_Q - jap_pkg::PI_Q)) begin
        sel = acc_r - AW'(jap_pkg::TWO_PI_Q);
      end else begin
        sel = acc_r;
      end
    end else begin
      priority if (acc_r > jap_pkg::ANG_MAX) begin
        sel = AW'(jap_pkg::ANG_MAX);
      end else if (acc_r < jap_pkg::ANG_MIN) begin
        sel = AW'(jap_pkg::ANG_MIN);
      end else begin
        sel = acc_r;
      end
    end
  end

  assign angle = sel[jap_pkg::ANGLE_W-1:0];

endmodule

@@ rtl/core/joint_angle_path_interpolator_core.sv @@
// After the input transfer a periodic joint has its angles wrapped; the divide is skipped
// when n is 0 or 1. Then one sample per cycle as the result side takes them. A new item is
// taken only once the one before has put its last sample in the output register;
// n = 0 gives no result. in_ch.ready is high only in idle. One shared adder runs the setup.
// Reset (rst_n, synchronous, active low) clears the sequencer, the output valid and the
// configuration registers to periodic_mask 15 and sample_count 2.
module joint_angle_path_interpolator_core (
  input  logic        clk,
  input  logic        rst_n,
  jap_cfg_if.sink     cfg_ch,
  jap_in_if.sink      in_ch,
  jap_out_if.source   out_ch
);

  localparam int AW = jap_pkg::ALU_W;

  // Configuration
  logic [jap_pkg::MASK_W-1:0]    mask_r;
  logic [jap_pkg::COUNT_W-1:0]   count_r;

  // Sequencer
  jap_pkg::seq_state_t           state_r;
  jap_pkg::seq_state_t           state_nxt;
  logic [jap_pkg::CNT_W-1:0]     cnt_r;
  logic                          wsel_r;

  // Item registers
  logic [jap_pkg::JOINT_W-1:0]   joint_r;
  logic                          per_r;
  logic [jap_pkg::COUNT_W-1:0]   n_r;
  logic signed [AW-1:0]          sa_r;
  logic signed [AW-1:0]          ga_r;
  logic signed [AW-1:0]          w_r;
  logic                          neg_r;
  logic [jap_pkg::QUO_W-1:0]     quo_r;
  logic [jap_pkg::DIV_W-1:0]     rem_r;
  logic signed [AW-1:0]          sq_r;
  logic [jap_pkg::COUNT_W-1:0]   k_r;

  // Output register
  logic                               out_valid_r;
  logic [jap_pkg::JOINT_W-1:0]        out_joint_r;
  logic [jap_pkg::INDEX_W-1:0]        out_index_r;
  logic signed [jap_pkg::ANGLE_W-1:0] out_angle_r;
  logic                               out_last_r;

  // Shared unit and stepper
  jap_pkg::alu_op_t              alu_op;
  logic signed [AW-1:0]          alu_a;
  logic signed [AW-1:0]          alu_b;
  logic signed [AW-1:0]          alu_y;
  logic                          alu_neg;
  jap_pkg::step_ctl_t            step_ctl;
  jap_pkg::step_init_t           step_init;
  logic signed [jap_pkg::ANGLE_W-1:0] step_angle;

  logic                          in_fire;
  logic                          joint_ok;
  logic                          out_fire;
  logic                          emit_go;
  logic                          last_now;
  logic [jap_pkg::DIV_W-1:0]     d;
  logic [jap_pkg::REM2_W-1:0]    div_t;
  logic signed [AW-1:0]          two_pi_a;
  logic signed [AW-1:0]          pi_a;

  assign two_pi_a = AW'(jap_pkg::TWO_PI_Q);
  assign pi_a     = AW'(jap_pkg::PI_Q);

  assign in_ch.ready  = (state_r == jap_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign joint_ok     = (int'(in_ch.joint_index) < jap_pkg::JOINTS);
  assign out_fire     = out_valid_r && out_ch.ready;

  assign d        = jap_pkg::DIV_W'(n_r - jap_pkg::COUNT_W'(1));
  assign div_t    = {rem_r, quo_r[jap_pkg::QUO_W-1]};
  assign last_now = (k_r == (n_r - jap_pkg::COUNT_W'(1)));
  assign emit_go  = (state_r == jap_pkg::ST_EMIT) && (k_r != n_r) &&
                    (!out_valid_r || out_ch.ready);

  jap_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y),
    .neg (alu_neg)
  );

  assign step_init.acc      = jap_pkg::ACC_W'(sa_r);
  assign step_init.sq       = jap_pkg::ACC_W'(sq_r);
  assign step_init.sq1      = jap_pkg::ACC_W'(alu_y);
  assign step_init.rem      = jap_pkg::REM2_W'(d);
  assign step_init.rem_step = {rem_r, 1'b0};
  assign step_init.two_d    = {d, 1'b0};
  assign step_init.periodic = per_r;

  jap_step u_step (
    .clk   (clk),
    .ctl   (step_ctl),
    .init  (step_init),
    .angle (step_angle)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jap_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and shared unit operands
  always_comb begin
    state_nxt        = state_r;
    alu_op           = jap_pkg::ALU_ADD;
    alu_a            = w_r;
    alu_b            = '0;
    step_ctl.load    = 1'b0;
    step_ctl.advance = emit_go;
    unique case (state_r)
      jap_pkg::ST_IDLE: begin
        if (in_fire && joint_ok) begin
          state_nxt = mask_r[in_ch.joint_index] ? jap_pkg::ST_WOFS : jap_pkg::ST_DIFF;
        end
      end
      jap_pkg::ST_WOFS: begin
        alu_a     = wsel_r ? ga_r : sa_r;
        alu_b     = pi_a;
        state_nxt = jap_pkg::ST_WLIFT;
      end
      jap_pkg::ST_WLIFT: begin
        alu_op    = jap_pkg::ALU_CADD;
        alu_b     = two_pi_a <<< jap_pkg::LIFT_SHIFT;
        state_nxt = jap_pkg::ST_WRED;
      end
      jap_pkg::ST_WRED: begin
        alu_op = jap_pkg::ALU_CSUB;
        alu_b  = two_pi_a <<< cnt_r[2:0];
        if (cnt_r == '0) begin
          state_nxt = jap_pkg::ST_WEND;
        end
      end
      jap_pkg::ST_WEND: begin
        alu_op    = jap_pkg::ALU_SUB;
        alu_b     = pi_a;
        state_nxt = wsel_r ? jap_pkg::ST_DIFF : jap_pkg::ST_WOFS;
      end
      jap_pkg::ST_DIFF: begin
        alu_op    = jap_pkg::ALU_SUB;
        alu_a     = ga_r;
        alu_b     = sa_r;
        state_nxt = per_r ? jap_pkg::ST_FOLD : jap_pkg::ST_MAG;
      end
      jap_pkg::ST_FOLD: begin
        priority if (w_r > jap_pkg::PI_Q) begin
          alu_op = jap_pkg::ALU_SUB;
          alu_b  = two_pi_a;
        end else if (w_r < -jap_pkg::PI_Q) begin
          alu_b  = two_pi_a;
        end else begin
          alu_b  = '0;
        end
        state_nxt = jap_pkg::ST_MAG;
      end
      jap_pkg::ST_MAG: begin
        alu_op    = w_r[AW-1] ? jap_pkg::ALU_SUB : jap_pkg::ALU_ADD;
        alu_a     = '0;
        alu_b     = w_r;
        state_nxt = (n_r > jap_pkg::COUNT_W'(1)) ? jap_pkg::ST_DIV : jap_pkg::ST_SQ;
      end
      jap_pkg::ST_DIV: begin
        alu_op = jap_pkg::ALU_CSUB;
        alu_a  = AW'(div_t);
        alu_b  = AW'(d);
        if (cnt_r == '0) begin
          state_nxt = jap_pkg::ST_SQ;
        end
      end
      jap_pkg::ST_SQ: begin
        alu_op    = neg_r ? jap_pkg::ALU_SUB : jap_pkg::ALU_ADD;
        alu_a     = '0;
        alu_b     = AW'(quo_r);
        state_nxt = jap_pkg::ST_SQ1;
      end
      jap_pkg::ST_SQ1: begin
        alu_op        = neg_r ? jap_pkg::ALU_SUB : jap_pkg::ALU_ADD;
        alu_a         = sq_r;
        alu_b         = AW'(1);
        step_ctl.load = 1'b1;
        state_nxt     = jap_pkg::ST_EMIT;
      end
      jap_pkg::ST_EMIT: begin
        if (k_r == n_r) begin
          state_nxt = jap_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = jap_pkg::ST_IDLE;
      end
    endcase
  end

  // Item datapath: latch, wrap, fold, divide and count samples
  always_ff @(posedge clk) begin
    unique case (state_r)
      jap_pkg::ST_IDLE: begin
        if (in_fire) begin
          joint_r <= in_ch.joint_index;
          per_r   <= mask_r[in_ch.joint_index];
          sa_r    <= AW'(in_ch.start_angle);
          ga_r    <= AW'(in_ch.goal_angle);
          wsel_r  <= 1'b0;
          n_r     <= (int'(count_r) > jap_pkg::MAX_SAMPLES) ?
                     jap_pkg::COUNT_W'(jap_pkg::MAX_SAMPLES) : count_r;
        end
      end
      jap_pkg::ST_WOFS: begin
        w_r <= alu_y;
      end
      jap_pkg::ST_WLIFT: begin
        w_r   <= alu_y;
        cnt_r <= jap_pkg::CNT_W'(jap_pkg::RED_STEPS - 1);
      end
      jap_pkg::ST_WRED: begin
        w_r   <= alu_y;
        cnt_r <= cnt_r - jap_pkg::CNT_W'(1);
      end
      jap_pkg::ST_WEND: begin
        if (wsel_r) begin
          ga_r <= alu_y;
        end else begin
          sa_r <= alu_y;
        end
        wsel_r <= 1'b1;
      end
      jap_pkg::ST_DIFF: begin
        w_r <= alu_y;
      end
      jap_pkg::ST_FOLD: begin
        w_r <= alu_y;
      end
      jap_pkg::ST_MAG: begin
        neg_r <= w_r[AW-1];
        quo_r <= alu_y[jap_pkg::QUO_W-1:0];
        rem_r <= '0;
        cnt_r <= jap_pkg::CNT_W'(jap_pkg::DIV_STEPS - 1);
      end
      jap_pkg::ST_DIV: begin
        rem_r <= alu_y[jap_pkg::DIV_W-1:0];
        quo_r <= {quo_r[jap_pkg::QUO_W-2:0], ~alu_neg};
        cnt_r <= cnt_r - jap_pkg::CNT_W'(1);
      end
      jap_pkg::ST_SQ: begin
        sq_r <= alu_y;
      end
      jap_pkg::ST_SQ1: begin
        k_r <= '0;
      end
      jap_pkg::ST_EMIT: begin
        if (emit_go) begin
          k_r <= k_r + jap_pkg::COUNT_W'(1);
        end
      end
      default: begin
        k_r <= k_r;
      end
    endcase
  end

  // Output register: load a sample, drop valid once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_joint_r <= joint_r;
      out_index_r <= k_r[jap_pkg::INDEX_W-1:0];
      out_angle_r <= step_angle;
      out_last_r  <= last_now;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.joint_tag    = out_joint_r;
  assign out_ch.sample_index = out_index_r;
  assign out_ch.path_angle   = out_angle_r;
  assign out_ch.last_sample  = out_last_r;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= jap_pkg::MASK_W'(15);
      count_r <= jap_pkg::COUNT_W'(2);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        jap_pkg::REG_PERIODIC_MASK: mask_r  <= cfg_ch.data[jap_pkg::MASK_W-1:0];
        jap_pkg::REG_SAMPLE_COUNT:  count_r <= cfg_ch.data;
        default: begin
          mask_r <= mask_r;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jap_pkg::ST_EMIT) |-> (k_r <= n_r))
    else $error("sample counter passed the sample count");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jap_pkg::ST_DIV) |-> (rem_r < d))
    else $error("divider remainder not below divisor");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && last_now) |=> (k_r == n_r))
    else $error("last sample sent before the run completed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && joint_ok) |=> !in_ch.ready)
    else $error("input ready while an item is in progress");

endmodule

@@ tb/sv/joint_angle_path_interpolator_core_tb.sv @@
// Testbench of the joint angle path interpolator core: predicts path samples and checks them.
module joint_angle_path_interpolator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jap_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int DRAIN_GUARD    = 120;
  localparam int HOLD_CYCLES    = 500;
  localparam int TIMEOUT_CYCLES = 600_000;
  localparam int SEGMENTS       = 4;
  localparam int SEGMENT_MOVES  = 32;
  localparam int PRESSURE_MOVES = 8;

  // Register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = REG_SAMPLE_COUNT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

  typedef struct packed {
    logic [JOINT_W-1:0]        joint;
    logic signed [ANGLE_W-1:0] start_angle;
    logic signed [ANGLE_W-1:0] goal_angle;
  } joint_move_t;

  typedef struct {
    logic [JOINT_W-1:0]        joint_tag;
    logic [INDEX_W-1:0]        sample_index;
    logic signed [ANGLE_W-1:0] path_angle;
    logic                      last_sample;
  } path_sample_t;

  logic clk = 1'b0;
  logic rst_n;

  jap_cfg_if cfg_ch ();
  jap_in_if  in_ch ();
  jap_out_if out_ch ();

  joint_angle_path_interpolator_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  joint_move_t  joint_moves[$];
  path_sample_t samples_due[$];

  // Mirror of the configuration and of the latest path set-up
  logic [MASK_W-1:0]         periodic_bits = 4'hF;
  logic [CFG_DATA_W-1:0]     samples_per_path = 7'd2;
  logic [COUNT_W-1:0]        latest_count = '0;
  logic signed [ANGLE_W-1:0] latest_start = '0;
  logic signed [ANGLE_W:0]   latest_diff = '0;
  logic [JOINT_W-1:0]        latest_joint = '0;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   error_count = 0;
  logic in_fire = 1'b0;
  logic hold_go = 1'b0;
  logic rx_hold = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Wrap an angle into [-pi, pi] the way the block does, with a floor modulo
  function automatic longint wrap_q16(longint x);
    longint r;
    r = (x + PI_Q) % TWO_PI_Q;
    if (r < 0) r += TWO_PI_Q;
    return r - PI_Q;
  endfunction

  // Divide and round to nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp_angle(longint x);
    if (x < ANG_MIN) return ANG_MIN;
    if (x > ANG_MAX) return ANG_MAX;
    return x;
  endfunction

  // Work out every sample of one joint's path and queue them in order
  function automatic void plan_path(logic [JOINT_W-1:0] joint,
                                    logic signed [ANGLE_W-1:0] start_in,
                                    logic signed [ANGLE_W-1:0] goal_in);
    longint       s;
    longint       g;
    longint       diff;
    longint       v;
    int           n;
    bit           periodic;
    path_sample_t smp;
    periodic = periodic_bits[joint];
    s = start_in;
    g = goal_in;
    if (periodic) begin
      s = wrap_q16(s);
      g = wrap_q16(g);
      diff = g - s;
      if (diff > PI_Q) diff -= TWO_PI_Q;
      else if (diff < -PI_Q) diff += TWO_PI_Q;
    end else begin
      diff = g - s;
    end
    n = (samples_per_path > MAX_SAMPLES) ? MAX_SAMPLES : int'(samples_per_path);
    latest_joint = joint;
    latest_start = s[ANGLE_W-1:0];
    latest_diff  = diff[ANGLE_W:0];
    latest_count = n[COUNT_W-1:0];
    for (int k = 0; k < n; k++) begin
      v = s;
      if (n > 1) v = s + round_div(diff * k, n - 1);
      v = periodic ? wrap_q16(v) : clamp_angle(v);
      smp.joint_tag    = joint;
      smp.sample_index = k[INDEX_W-1:0];
      smp.path_angle   = v[ANGLE_W-1:0];
      smp.last_sample  = (k == n - 1);
      samples_due.insert(samples_due.size(), smp);
    end
  endfunction

  // Register the input transfer for the driver
  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
  end

  // Drive the input channel from the queue of pending moves
  always @(negedge clk) begin : drive_moves
    joint_move_t mv;
    logic        offer;
    offer = in_ch.valid && !in_fire;
    if (!offer && joint_moves.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      mv = joint_moves.pop_front();
      in_ch.joint_index <= mv.joint;
      in_ch.start_angle <= mv.start_angle;
      in_ch.goal_angle  <= mv.goal_angle;
      offer = 1'b1;
    end
    in_ch.valid <= offer;
  end

  // Stall the result channel at random, or hard while a hold-off runs
  always @(negedge clk) begin
    out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hold the receiver off for a long stretch once asked to
  initial begin : stall_receiver
    wait (hold_go);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // Track register writes, predict on input transfers, check result transfers
  always @(posedge clk) begin : watch_channels
    path_sample_t due;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_PERIODIC_MASK: periodic_bits = cfg_ch.data[MASK_W-1:0];
          REG_SAMPLE_COUNT:  samples_per_path = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        plan_path(in_ch.joint_index, in_ch.start_angle, in_ch.goal_angle);
      if (out_ch.valid && out_ch.ready) begin
        if (samples_due.size() == 0) begin
          $error("unexpected sample: joint_tag %0d sample_index %0d path_angle %0d",
                 out_ch.joint_tag, out_ch.sample_index, out_ch.path_angle);
          error_count++;
        end else begin
          due = samples_due.pop_front();
          if (out_ch.joint_tag !== due.joint_tag) begin
            $error("joint_tag: expected %0d, got %0d", due.joint_tag, out_ch.joint_tag);
            error_count++;
          end
          if (out_ch.sample_index !== due.sample_index) begin
            $error("sample_index: expected %0d, got %0d", due.sample_index,
                   out_ch.sample_index);
            error_count++;
          end
          if (out_ch.path_angle !== due.path_angle) begin
            $error("path_angle: expected %0d, got %0d", due.path_angle, out_ch.path_angle);
            error_count++;
          end
          if (out_ch.last_sample !== due.last_sample) begin
            $error("last_sample: expected %0d, got %0d", due.last_sample,
                   out_ch.last_sample);
            error_count++;
          end
        end
      end
    end
  end

  task automatic add_move(input logic [JOINT_W-1:0] joint, input int start_q, input int goal_q);
    joint_move_t mv;
    mv.joint       = joint;
    mv.start_angle = start_q[ANGLE_W-1:0];
    mv.goal_angle  = goal_q[ANGLE_W-1:0];
    joint_moves.insert(joint_moves.size(), mv);
  endtask

  // Favour the field extremes, the wrap boundaries and up to two turns either way
  function automatic int pick_angle();
    int v;
    case ($urandom_range(0, 7))
      0: v = ANG_MIN + int'($urandom_range(0, 3));
      1: v = ANG_MAX - int'($urandom_range(0, 3));
      2: v = ($urandom_range(0, 1) ? PI_Q : -PI_Q) + int'($urandom_range(0, 4)) - 2;
      3: v = int'($urandom_range(0, 4 * TWO_PI_Q)) - 2 * TWO_PI_Q;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Near goals give rounding ties on short paths
  task automatic add_random_move();
    int s;
    int g;
    s = pick_angle();
    g = ($urandom_range(0, 3) == 0) ? s + int'($urandom_range(0, 6)) - 3 : pick_angle();
    add_move(JOINT_W'($urandom_range(0, JOINTS - 1)), s, g);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every move is taken and every sample is back, then let the block go idle
  task automatic settle();
    do @(posedge clk);
    while (joint_moves.size() != 0 || in_ch.valid || samples_due.size() != 0);
    repeat (DRAIN_GUARD) @(posedge clk);
  endtask

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] cnt;
    settle();
    write_reg(REG_PERIODIC_MASK, CFG_DATA_W'($urandom_range(0, 127)));
    case ($urandom_range(0, 9))
      0: cnt = 0;
      1: cnt = 1;
      2: cnt = CFG_DATA_W'(MAX_SAMPLES);
      3: cnt = CFG_DATA_W'($urandom_range(MAX_SAMPLES + 1, 127));
      default: cnt = CFG_DATA_W'($urandom_range(2, 16));
    endcase
    write_reg(REG_SAMPLE_COUNT, cnt);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_TOP)),
                CFG_DATA_W'($urandom_range(0, 127)));
  endtask

  initial begin : run_test
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.joint_index = '0;
    in_ch.start_angle = '0;
    in_ch.goal_angle = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 6;
    recv_idle_pct = 58;

    // Reset settings: all joints periodic, two samples
    add_move(0, 0, 0);
    add_move(1, ANG_MAX, ANG_MIN);
    add_move(2, -PI_Q, PI_Q);
    add_move(3, 0, PI_Q);
    add_move(0, 0, -PI_Q - 1);
    settle();

    // Rounding ties either way on a three-sample path
    write_reg(REG_SAMPLE_COUNT, 3);
    add_move(1, 0, 1);
    add_move(2, 0, -1);
    settle();

    // Single sample gives the wrapped start alone
    write_reg(REG_SAMPLE_COUNT, 1);
    add_move(3, 100000, -100000);
    settle();

    // Zero samples: moves are taken but give nothing
    write_reg(REG_SAMPLE_COUNT, 0);
    add_move(0, 12345, 54321);
    add_move(3, ANG_MIN, ANG_MAX);
    settle();

    // No joint periodic, count above the limit saturates
    write_reg(REG_PERIODIC_MASK, 7'h70);
    write_reg(REG_SAMPLE_COUNT, 127);
    add_move(0, ANG_MIN, ANG_MAX);
    add_move(1, ANG_MAX, ANG_MIN);
    add_move(2, 1, -1);
    settle();

    // Writes past the register list change nothing
    write_reg(REG_UNUSED_LOW, 7'h7F);
    write_reg(REG_UNUSED_TOP, 7'h55);
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(MAX_SAMPLES + 1));
    add_move(3, -5000000, 7000000);
    settle();

    // Mixed mask: joints 0 and 2 wrap, full-length paths
    write_reg(REG_PERIODIC_MASK, 7'h05);
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(MAX_SAMPLES));
    add_move(0, 3 * PI_Q, -3 * PI_Q);
    add_move(1, ANG_MAX, 0);
    add_move(2, 8000000, -8000000);
    add_move(3, -PI_Q, PI_Q);
    settle();
    write_reg(REG_SAMPLE_COUNT, 2);
    add_move(0, PI_Q + 1, -PI_Q);

    // Random segments under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 6;  recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 6;  end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Fill the block while the receiver is held off
          settle();
          write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(MAX_SAMPLES));
          hold_go = 1'b1;
          repeat (PRESSURE_MOVES) add_random_move();
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        random_settings();
        repeat (SEGMENT_MOVES) add_random_move();
      end
    end

    settle();
    if (error_count == 0)
      $display("joint_angle_path_interpolator_core: match");
    else
      $display("joint_angle_path_interpolator_core: mismatch");
    $finish;
  end

  // Abort a hung run
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("joint_angle_path_interpolator_core: mismatch");
    $finish;
  end

endmodule
